>>> hdl/fppt_pkg.sv
`default_nettype none

package fppt_pkg;

  // Fixed-point format of the coefficients (signed 3.29)
  localparam int unsigned FracBits = 29;

  // Number of 64-bit pair registers and the register index width
  localparam int unsigned NumPairs = 6;
  localparam int unsigned CfgIdxW  = 8;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_PAIR_0 = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_TRANS  = CfgIdxW'(6);

  // Width of the product bits that can reach the result (bits 0 to 60)
  localparam int unsigned ProdW = 61;
  // Width of the kept sum slice (bits 28 to 60)
  localparam int unsigned KeepW = ProdW - (FracBits - 1);

  typedef logic signed [31:0] word_t;
  typedef word_t [2:0]        vec3_t;
  typedef vec3_t [2:0]        mat3_t;

  typedef logic [5:0][63:0]   pairs_t;

  // Reset contents of the pair registers: identity matrix, no translation
  localparam pairs_t PAIR_RESET = {
    64'h0000_0000_0000_0000,
    64'h0000_0000_2000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_2000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_2000_0000
  };

  // Decoded configuration handed to the datapath
  typedef struct packed {
    mat3_t coef;
    vec3_t offs;
    logic  trans;
  } cfg_t;

  typedef logic [2:0][2:0][ProdW-1:0] prod_t;
  typedef logic [2:0][KeepW-1:0]      sum_t;

endpackage

`default_nettype wire

>>> hdl/fppt_cfg.sv
`default_nettype none

module fppt_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [fppt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]                  cfg_data_i,
  output fppt_pkg::cfg_t                    cfg_o
);
  import fppt_pkg::*;

  pairs_t pair_q;
  logic   trans_q;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  // Take register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q  <= PAIR_RESET;
      trans_q <= 1'b1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i < (REG_PAIR_0 + CfgIdxW'(NumPairs))) begin
        pair_q[cfg_index_i[2:0]] <= cfg_data_i;
      end else if (cfg_index_i == REG_TRANS) begin
        trans_q <= cfg_data_i[0];
      end
    end
  end

  // Unpack the twelve 32-bit words into matrix and offsets
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      cfg_o.coef[k / 3][k % 3] = pair_q[k / 2][(k % 2) * 32 +: 32];
    end
    for (int r = 0; r < 3; r++) begin
      cfg_o.offs[r] = pair_q[(9 + r) / 2][((9 + r) % 2) * 32 +: 32];
    end
    cfg_o.trans = trans_q;
  end

endmodule

`default_nettype wire

>>> hdl/fppt_mul.sv
`default_nettype none

module fppt_mul (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  fppt_pkg::vec3_t     point_i,
  input  fppt_pkg::mat3_t     coef_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output fppt_pkg::prod_t     prod_o
);
  import fppt_pkg::*;

  logic  valid_q;
  prod_t prod_d, prod_q;

  assign ready_o = !valid_q || ready_i;

  // Nine 32x32 signed products; only the low 61 bits reach the result
  always_comb begin
    logic signed [63:0] p;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p = $signed(coef_i[r][c]) * $signed(point_i[c]);
        prod_d[r][c] = p[ProdW-1:0];
      end
    end
  end

  // Advance the stage when the next one can take it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

`default_nettype wire

>>> hdl/fppt_acc.sv
`default_nettype none

module fppt_acc (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  fppt_pkg::prod_t prod_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output fppt_pkg::sum_t  sum_o
);
  import fppt_pkg::*;

  logic             valid_q;
  sum_t             sum_d, sum_q;
  logic [ProdW-1:0] row_sum;

  assign ready_o = !valid_q || ready_i;

  // Add the three products of each row, wrapping; keep bits 28 to 60
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum  = prod_i[r][0] + prod_i[r][1] + prod_i[r][2];
      sum_d[r] = row_sum[ProdW-1:FracBits-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sum_q <= sum_d;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;

endmodule

`default_nettype wire

>>> hdl/fppt_rnd.sv
`default_nettype none

module fppt_rnd (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  fppt_pkg::sum_t  sum_i,
  input  fppt_pkg::vec3_t offs_i,
  input  wire logic       trans_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output fppt_pkg::vec3_t point_o
);
  import fppt_pkg::*;

  logic  valid_q;
  vec3_t point_d, point_q;

  assign ready_o = !valid_q || ready_i;

  // Drop the fraction, round on bit 28, add the offset when enabled
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      point_d[r] = sum_i[r][KeepW-1:1] + {31'b0, sum_i[r][0]}
                 + (trans_i ? offs_i[r] : 32'sd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      point_q <= point_d;
    end
  end

  assign valid_o = valid_q;
  assign point_o = point_q;

endmodule

`default_nettype wire

>>> hdl/fixed_point_point_transform.sv
// Channel  | Dir | Handshake               | Payload
// s_axis   | in  | s_axis_tvalid/tready    | tdata[95:0]: x_in, y_in, z_in
// m_axis   | out | m_axis_tvalid/tready    | tdata[95:0]: x_out, y_out, z_out
// cfg      | in  | cfg_valid/cfg_ready     | cfg_index (register), cfg_data (64 bits)
//
// One point per cycle while the output is not stalled; the result passes
// four register stages after the input transfer: input register, nine
// multipliers, row adders, rounding.
// Each stage has its own valid bit and takes a new point when it is empty or
// its contents move on, so bubbles close up while the output is stalled.
// Reset clears the valid bits and loads the identity matrix, zero offsets
// and translation enabled; the configuration port is always ready.
`default_nettype none

module fixed_point_point_transform (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // x_in [31:0], y_in [63:32], z_in [95:64]
  input  wire logic [95:0]                  s_axis_tdata_i,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // x_out [31:0], y_out [63:32], z_out [95:64]
  output logic [95:0]                       m_axis_tdata_o,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [fppt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]                  cfg_data_i
);
  import fppt_pkg::*;

  cfg_t  cfg;
  logic  in_valid_q;
  vec3_t in_point_q;
  logic  mul_ready, mul_valid;
  prod_t mul_prod;
  logic  acc_ready, acc_valid;
  sum_t  acc_sum;
  logic  rnd_ready;
  vec3_t out_point;

  fppt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register stage
  assign s_axis_tready_o = !in_valid_q || mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_point_q <= s_axis_tdata_i;
    end
  end

  fppt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .ready_o (mul_ready),
    .point_i (in_point_q),
    .coef_i  (cfg.coef),
    .valid_o (mul_valid),
    .ready_i (acc_ready),
    .prod_o  (mul_prod)
  );

  fppt_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (acc_ready),
    .prod_i  (mul_prod),
    .valid_o (acc_valid),
    .ready_i (rnd_ready),
    .sum_o   (acc_sum)
  );

  fppt_rnd u_rnd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc_valid),
    .ready_o (rnd_ready),
    .sum_i   (acc_sum),
    .offs_i  (cfg.offs),
    .trans_i (cfg.trans),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .point_o (out_point)
  );

  assign m_axis_tdata_o = out_point;

endmodule

`default_nettype wire

>>> hdl/fppt_chk.sv
`default_nettype none

module fppt_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [95:0] m_axis_tdata_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i
);

  logic [2:0] cnt_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // Count points held inside the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_q + {2'b0, in_xfer} - {2'b0, out_xfer};
    end
  end

  // No result while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // A result only ever follows an accepted point
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> cnt_q != 3'd0)
    else $error("result without a pending point");

  // Never more points in flight than pipeline stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("pipeline overfilled");

  // An empty output stage means the whole pipe can take input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind fixed_point_point_transform fppt_chk u_chk (.*);

`default_nettype wire

>>> tb/sv/tb_fixed_point_point_transform.sv
`default_nettype none

module tb_fixed_point_point_transform;
  import fppt_pkg::*;

  // Extra register indexes used by the stimulus
  localparam logic [CfgIdxW-1:0] REG_PAIR_1 = REG_PAIR_0 + CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_PAIR_2 = REG_PAIR_0 + CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_PAIR_3 = REG_PAIR_0 + CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] REG_PAIR_4 = REG_PAIR_0 + CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] REG_PAIR_5 = REG_PAIR_0 + CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] REG_BEYOND = REG_TRANS + CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_LAST   = '1;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned NumPhases    = 10;
  localparam int unsigned PhaseItems   = 164;

  // Word classes for coefficients, offsets and coordinates
  typedef enum int {WK_UNIT, WK_FULL, WK_EXTREME, WK_SMALL} word_kind_e;

  // Directed stimulus table
  typedef enum logic {ROW_POINT, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic               typed;
    logic [CfgIdxW-1:0] index;
    logic [95:0]        data;
    logic [95:0]        want;
  } row_t;

  localparam int unsigned NumRows = 23;
  localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
  localparam logic [31:0] MINW = 32'h8000_0000;

  localparam row_t DIRECTED_ROWS [NumRows] = '{
    // identity after reset: points pass unchanged
    '{ROW_POINT, 1'b1, '0, {32'h0, 32'h0, 32'h0}, {32'h0, 32'h0, 32'h0}},
    '{ROW_POINT, 1'b1, '0, {32'hFFFF_FFFF, MINW, MAXW}, {32'hFFFF_FFFF, MINW, MAXW}},
    '{ROW_POINT, 1'b1, '0, {32'h1, MAXW, MINW}, {32'h1, MAXW, MINW}},
    // all coefficients at -4.0, offsets at the extremes
    '{ROW_CFG, 1'b0, REG_PAIR_0, {32'h0, MINW, MINW}, '0},
    '{ROW_CFG, 1'b0, REG_PAIR_1, {32'h0, MINW, MINW}, '0},
    '{ROW_CFG, 1'b0, REG_PAIR_2, {32'h0, MINW, MINW}, '0},
    '{ROW_CFG, 1'b0, REG_PAIR_3, {32'h0, MINW, MINW}, '0},
    '{ROW_CFG, 1'b0, REG_PAIR_4, {32'h0, MAXW, MINW}, '0},
    '{ROW_CFG, 1'b0, REG_PAIR_5, {32'h0, MINW, MAXW}, '0},
    // product sum wraps past 64 bits
    '{ROW_POINT, 1'b0, '0, {MINW, MINW, MINW}, '0},
    '{ROW_POINT, 1'b0, '0, {MAXW, MAXW, MAXW}, '0},
    '{ROW_POINT, 1'b0, '0, {32'h0, 32'hFFFF_FFFF, 32'h1}, '0},
    // rotate only
    '{ROW_CFG, 1'b0, REG_TRANS, 96'h0, '0},
    '{ROW_POINT, 1'b0, '0, {MINW, MAXW, MINW}, '0},
    // upper bits of the enable are dropped, so translation stays off
    '{ROW_CFG, 1'b0, REG_TRANS, {32'h0, 64'hFFFF_FFFF_FFFF_FFFE}, '0},
    '{ROW_POINT, 1'b0, '0, {32'h1, 32'h1, 32'h1}, '0},
    // writes past the last register are ignored
    '{ROW_CFG, 1'b0, REG_BEYOND, {32'h0, 64'h0123_4567_89AB_CDEF}, '0},
    '{ROW_CFG, 1'b0, REG_LAST, {32'h0, 64'hFFFF_FFFF_FFFF_FFFF}, '0},
    '{ROW_POINT, 1'b0, '0, {32'h0, MINW, MAXW}, '0},
    // translation back on, first two row 0 coefficients at 0.5: rounding and result wrap
    '{ROW_CFG, 1'b0, REG_TRANS, {32'h0, 64'hFFFF_FFFF_FFFF_FFFF}, '0},
    '{ROW_CFG, 1'b0, REG_PAIR_0, {32'h0, 64'h1000_0000_1000_0000}, '0},
    '{ROW_POINT, 1'b0, '0, {32'h0, 32'h1, 32'h1}, '0},
    '{ROW_POINT, 1'b0, '0, {32'h0, 32'h0, 32'h1}, '0}
  };

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b1;
  logic [95:0]        s_axis_tdata_i  = '0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [95:0]        m_axis_tdata_o;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i     = '0;
  logic [63:0]        cfg_data_i      = '0;

  // Shadow of the configuration and the queue of expected points
  pairs_t      coef_pairs  = PAIR_RESET;
  logic        offs_enable = 1'b1;
  logic [95:0] pending_points [$];

  // Expectation typed into the table for the point being sent
  logic        typed_pending = 1'b0;
  logic [95:0] typed_point   = '0;

  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;
  int   mismatches = 0;

  fixed_point_point_transform dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Affine transform of one point with the given coefficients and offsets
  function automatic logic [95:0] transform_point(input logic [95:0] pt,
                                                  input pairs_t pairs,
                                                  input logic add_offs);
    word_t       words [12];
    word_t       coord [3];
    logic [63:0] acc;
    logic [31:0] row_val;
    logic [95:0] res;
    for (int k = 0; k < 12; k++) begin
      words[k] = (k % 2 == 1) ? pairs[k / 2][63:32] : pairs[k / 2][31:0];
    end
    for (int c = 0; c < 3; c++) begin
      coord[c] = pt[32 * c +: 32];
    end
    for (int r = 0; r < 3; r++) begin
      acc = '0;
      for (int c = 0; c < 3; c++) begin
        acc += 64'(longint'(words[r * 3 + c]) * longint'(coord[c]));
      end
      // keep bits 29 up, round on bit 28
      row_val = acc[60:29] + 32'(acc[28]);
      if (add_offs) begin
        row_val += words[9 + r];
      end
      res[32 * r +: 32] = row_val;
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_word(input word_kind_e kind);
    logic [31:0] w;
    case (kind)
      WK_UNIT:  w = 32'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
      WK_SMALL: w = 32'($urandom_range(0, 2000)) - 32'd1000;
      WK_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       w = MAXW;
          1:       w = MINW;
          2:       w = 32'h0;
          3:       w = 32'h1;
          default: w = 32'hFFFF_FFFF;
        endcase
      end
      default:  w = $urandom();
    endcase
    return w;
  endfunction

  function automatic word_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return WK_FULL;
    if (r < 70) return WK_UNIT;
    if (r < 85) return WK_SMALL;
    return WK_EXTREME;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int unsigned pick_gap(input logic calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offer one point, hold until the transfer, then drop valid for a random gap, which may be none
  task automatic send_point(input logic [95:0] pt, input logic typed,
                            input logic [95:0] want);
    int unsigned gap;
    @(negedge clk_i);
    typed_pending = typed;
    typed_point   = want;
    s_axis_tdata_i  <= pt;
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    gap = pick_gap(tx_calm);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid and wait until every expected point has come out
  task automatic drain_points();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Check results, record accepted points, track register writes
  always @(posedge clk_i) begin : track
    logic [95:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_points.size() == 0) begin
          flag_mismatch($sformatf("result %h with none expected", m_axis_tdata_o));
        end else begin
          want = pending_points.pop_front();
          for (int f = 0; f < 3; f++) begin
            if (m_axis_tdata_o[32 * f +: 32] !== want[32 * f +: 32]) begin
              flag_mismatch($sformatf("coordinate %0d got %h want %h", f,
                                      m_axis_tdata_o[32 * f +: 32], want[32 * f +: 32]));
            end
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pending_points.push_back(typed_pending ? typed_point :
                                 transform_point(s_axis_tdata_i, coef_pairs, offs_enable));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i <= REG_PAIR_5) begin
          coef_pairs[cfg_index_i[2:0]] = cfg_data_i;
        end else if (cfg_index_i == REG_TRANS) begin
          offs_enable = cfg_data_i[0];
        end
      end
    end
  end

  // Result side: random stalls, calm stretches when asked
  initial begin : sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        stall_left = pick_gap(rx_calm);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] words [12];
    logic [63:0] enable_word;
    logic [95:0] pt;
    word_kind_e  coef_kind;
    word_kind_e  offs_kind;

    // Assert reset with a falling edge so the asynchronous reset is seen
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < NumRows; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
        drain_points();
        write_reg(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].data[63:0]);
      end else begin
        send_point(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
    end

    // Random phases, each with a fresh configuration
    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_points();
      coef_kind = (phase < 4) ? word_kind_e'(phase) : pick_kind();
      offs_kind = pick_kind();
      for (int k = 0; k < 12; k++) begin
        words[k] = rand_word(k < 9 ? coef_kind : offs_kind);
      end
      for (int k = 0; k < 6; k++) begin
        write_reg(REG_PAIR_0 + CfgIdxW'(k), {words[2 * k + 1], words[2 * k]});
      end
      enable_word = {$urandom(), $urandom()};
      enable_word[0] = (phase % 3 != 1);
      write_reg(REG_TRANS, enable_word);
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CfgIdxW'($urandom_range(REG_BEYOND, REG_LAST)), {$urandom(), $urandom()});
      end
      tx_calm = (phase % 4 == 1) || ($urandom_range(0, 4) == 0);
      rx_calm = (phase % 4 == 1) || ($urandom_range(0, 4) == 0);
      for (int n = 0; n < PhaseItems; n++) begin
        pt = {rand_word(pick_kind()), rand_word(pick_kind()), rand_word(pick_kind())};
        send_point(pt, 1'b0, '0);
      end
    end

    tx_calm = 1'b0;
    rx_calm = 1'b0;
    drain_points();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
